// ----- sv/assert_macros.svh -----
// Assertion macros shared by the deframer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SPD_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SPD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ----- sv/spd_pkg.sv -----
// Shared types and constants of the SLIP packet deframer.
package spd_pkg;

    typedef enum logic [1:0] {
        RX_IDLE   = 2'd0,
        RX_FRAME  = 2'd1,
        RX_ESCAPE = 2'd2,
        RX_ERROR  = 2'd3
    } rx_mode_t;

    localparam logic       OP_RECEIVE = 1'b0;
    localparam logic       OP_READ    = 1'b1;

    localparam logic [1:0] KIND_READY = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic       ERR_BAD_ESCAPE = 1'b0;
    localparam logic       ERR_OVERFLOW   = 1'b1;

    localparam logic [7:0] SLIP_END     = 8'hC0;
    localparam logic [7:0] SLIP_ESC     = 8'hDB;
    localparam logic [7:0] SLIP_ESC_END = 8'hDC;
    localparam logic [7:0] SLIP_ESC_ESC = 8'hDD;

    // Decisions of the receive controller for one serial byte.
    typedef struct packed {
        logic       wr_en;
        logic [7:0] wr_data;
        logic       emit;
        logic [1:0] kind;
        logic       err_code;
    } rx_cmd_t;

endpackage

// ----- sv/spd_buffer.sv -----
// Packet buffer: one write port, one registered read port.
module spd_buffer #(
    parameter int DEPTH = 2048,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- sv/spd_rx_ctrl.sv -----
// Receive controller: SLIP mode machine and frame byte count.
module spd_rx_ctrl import spd_pkg::*; #(
    parameter int BUFFER_BYTES = 2048,
    localparam int CW = $clog2(BUFFER_BYTES + 1)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          step,
    input  logic [7:0]    rx_byte,
    output rx_cmd_t       cmd,
    output logic [CW-1:0] count
);

    rx_mode_t      mode_reg;
    rx_mode_t      mode_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= RX_IDLE;
            count_reg <= '0;
        end
        else
        begin
            mode_reg  <= mode_next;
            count_reg <= count_next;
        end
    end

    always_comb
    begin
        full       = (count_reg == CW'(BUFFER_BYTES));
        mode_next  = mode_reg;
        count_next = count_reg;
        cmd        = '0;
        case (mode_reg)
            RX_IDLE, RX_FRAME:
            begin
                if (rx_byte == SLIP_END)
                begin
                    if (mode_reg == RX_IDLE)
                    begin
                        mode_next = RX_FRAME;
                    end
                    else
                    begin
                        mode_next = RX_IDLE;
                        if (count_reg != '0)
                        begin
                            count_next = '0;
                            // report only whole 32-bit words
                            if (count_reg[1:0] == 2'b00)
                            begin
                                cmd.emit = 1'b1;
                                cmd.kind = KIND_READY;
                            end
                        end
                    end
                end
                else if (rx_byte == SLIP_ESC)
                begin
                    mode_next = RX_ESCAPE;
                end
                else if (!full)
                begin
                    mode_next   = RX_FRAME;
                    cmd.wr_en   = 1'b1;
                    cmd.wr_data = rx_byte;
                    count_next  = count_reg + CW'(1);
                end
                else
                begin
                    mode_next    = RX_ERROR;
                    cmd.emit     = 1'b1;
                    cmd.kind     = KIND_ERROR;
                    cmd.err_code = ERR_OVERFLOW;
                end
            end
            RX_ESCAPE:
            begin
                if (rx_byte == SLIP_ESC_END || rx_byte == SLIP_ESC_ESC)
                begin
                    if (!full)
                    begin
                        mode_next   = RX_FRAME;
                        cmd.wr_en   = 1'b1;
                        cmd.wr_data = (rx_byte == SLIP_ESC_END) ? SLIP_END : SLIP_ESC;
                        count_next  = count_reg + CW'(1);
                    end
                    else
                    begin
                        mode_next    = RX_ERROR;
                        cmd.emit     = 1'b1;
                        cmd.kind     = KIND_ERROR;
                        cmd.err_code = ERR_OVERFLOW;
                    end
                end
                else
                begin
                    mode_next    = RX_ERROR;
                    cmd.emit     = 1'b1;
                    cmd.kind     = KIND_ERROR;
                    cmd.err_code = ERR_BAD_ESCAPE;
                end
            end
            RX_ERROR:
            begin
                // drop bytes until END, then start over
                if (rx_byte == SLIP_END)
                begin
                    mode_next  = RX_IDLE;
                    count_next = '0;
                end
            end
            default:
            begin
                mode_next = RX_IDLE;
            end
        endcase
        // hold everything when no byte is taken
        if (!step)
        begin
            mode_next  = mode_reg;
            count_next = count_reg;
            cmd        = '0;
        end
    end

    assign count = count_reg;

endmodule

// ----- sv/slip_packet_deframer_core.sv -----
// Top level of the SLIP packet deframer with packet buffer.
//
// Request channel (item_valid/item_ready): opcode 0 feeds one serial byte
// (rx_byte) to the deframer, opcode 1 reads the packet buffer at read_index.
// Result channel (result_valid/result_ready): kind 0 packet ready with
// packet_length, kind 1 read data, kind 2 framing error with error_code.
// Fields that do not belong to the result kind read as zero.
// Throughput: one request per cycle while item_ready is high. A request
// passes an entry stage, in which the registered buffer read port delivers
// its data, then the output register that drives result_valid.
// Receive requests that close nothing give no result and leave no
// trace in the pipeline.
// Receiver stall: the output register holds its result; one more request
// with a result is parked in the entry stage, after which item_ready drops
// until the output drains.
// Reset: mode goes idle and the frame count clears at once; buffer contents
// stay undefined, so read only positions written since reset.
`include "assert_macros.svh"

module slip_packet_deframer_core import spd_pkg::*; #(
    parameter int BUFFER_BYTES = 2048
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  logic        opcode,
    input  logic [7:0]  rx_byte,
    input  logic [10:0] read_index,
    output logic        result_valid,
    input  logic        result_ready,
    output logic [1:0]  kind,
    output logic [11:0] packet_length,
    output logic [7:0]  read_data,
    output logic        error_code
);

    localparam int CW = $clog2(BUFFER_BYTES + 1);
    localparam int AW = $clog2(BUFFER_BYTES);

    logic            accept;
    logic            step;
    logic            rd_en;
    logic            move;
    rx_cmd_t         cmd;
    logic [CW-1:0]   count;
    logic [CW+11:0]  count_wide;
    logic [AW+10:0]  ridx_wide;
    logic            in_range;
    logic [7:0]      rdata;

    // entry stage
    logic            s1_valid_reg;
    logic            s1_valid_next;
    logic [1:0]      s1_kind_reg;
    logic [1:0]      s1_kind_next;
    logic [11:0]     s1_len_reg;
    logic [11:0]     s1_len_next;
    logic            s1_err_reg;
    logic            s1_err_next;
    logic            s1_range_reg;
    logic            s1_range_next;

    // output register
    logic            result_valid_reg;
    logic            result_valid_next;
    logic [1:0]      kind_reg;
    logic [1:0]      kind_next;
    logic [11:0]     len_reg;
    logic [11:0]     len_next;
    logic [7:0]      data_reg;
    logic [7:0]      data_next;
    logic            err_reg;
    logic            err_next;

    // Handshake: the entry stage frees up when it drains into the output.
    assign move       = s1_valid_reg && (!result_valid_reg || result_ready);
    assign item_ready = !s1_valid_reg || move;
    assign accept     = item_valid && item_ready;
    assign step       = accept && (opcode == OP_RECEIVE);
    assign rd_en      = accept && (opcode == OP_READ);

    // Length reports the low 12 bits of the frame count.
    assign count_wide = {12'b0, count};

    // Positions at or beyond the buffer read as zero.
    assign ridx_wide  = {{AW{1'b0}}, read_index};
    assign in_range   = (ridx_wide < (AW + 11)'(BUFFER_BYTES));

    spd_rx_ctrl #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_rx_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .rx_byte (rx_byte),
        .cmd     (cmd),
        .count   (count)
    );

    // Write at the current count; the controller never writes when full.
    spd_buffer #(
        .DEPTH (BUFFER_BYTES)
    ) u_buffer (
        .clk     (clk),
        .wr_en   (cmd.wr_en),
        .wr_addr (count[AW-1:0]),
        .wr_data (cmd.wr_data),
        .rd_en   (rd_en),
        .rd_addr (ridx_wide[AW-1:0]),
        .rd_data (rdata)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s1_kind_next  = s1_kind_reg;
        s1_len_next   = s1_len_reg;
        s1_err_next   = s1_err_reg;
        s1_range_next = s1_range_reg;
        if (move)
        begin
            s1_valid_next = 1'b0;
        end
        if (rd_en)
        begin
            s1_valid_next = 1'b1;
            s1_kind_next  = KIND_READ;
            s1_len_next   = '0;
            s1_err_next   = 1'b0;
            s1_range_next = in_range;
        end
        else if (cmd.emit)
        begin
            s1_valid_next = 1'b1;
            s1_kind_next  = cmd.kind;
            s1_len_next   = (cmd.kind == KIND_READY) ? count_wide[11:0] : 12'd0;
            s1_err_next   = cmd.err_code;
            s1_range_next = 1'b0;
        end
    end

    always_comb
    begin
        result_valid_next = result_valid_reg;
        kind_next         = kind_reg;
        len_next          = len_reg;
        data_next         = data_reg;
        err_next          = err_reg;
        if (move)
        begin
            // read data lands in the same cycle the entry stage is full
            result_valid_next = 1'b1;
            kind_next         = s1_kind_reg;
            len_next          = s1_len_reg;
            data_next         = s1_range_reg ? rdata : 8'd0;
            err_next          = s1_err_reg;
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg     <= s1_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_kind_reg  <= s1_kind_next;
        s1_len_reg   <= s1_len_next;
        s1_err_reg   <= s1_err_next;
        s1_range_reg <= s1_range_next;
        kind_reg     <= kind_next;
        len_reg      <= len_next;
        data_reg     <= data_next;
        err_reg      <= err_next;
    end

    assign result_valid  = result_valid_reg;
    assign kind          = kind_reg;
    assign packet_length = len_reg;
    assign read_data     = data_reg;
    assign error_code    = err_reg;

    `SPD_ASSERT_IMPL(a_no_write_when_full, cmd.wr_en, count != CW'(BUFFER_BYTES))
    `SPD_ASSERT_NEXT(a_read_enters_stage, rd_en, s1_valid_reg && s1_kind_reg == KIND_READ)
    `SPD_ASSERT_IMPL(a_stall_only_when_full, !item_ready, s1_valid_reg && result_valid_reg && !result_ready)

endmodule
